// ===== rtl/bus_slave_framer_backoff_macros.svh =====
// Assertion macros shared by the bus slave framer RTL.
`ifndef BUS_SLAVE_FRAMER_BACKOFF_MACROS_SVH
`define BUS_SLAVE_FRAMER_BACKOFF_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define BSFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that implies a consequence at the following edge.
`define BSFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSFB_ASSERT(lbl, prop, msg)
`define BSFB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/bsfb_pkg.sv =====
// Package with the types and constants of the bus slave framer.
package bsfb_pkg;

  localparam int unsigned MaxPacketDefault = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [3:0] {
    KIND_RX_MESSAGE = 4'd0,
    KIND_QUERY      = 4'd1,
    KIND_DISCOVER   = 4'd2,
    KIND_EDGE       = 4'd3,
    KIND_TICK       = 4'd4,
    KIND_TX_READY   = 4'd5,
    KIND_TX_END     = 4'd6,
    KIND_LOAD       = 4'd7,
    KIND_FETCH      = 4'd8,
    KIND_RANDOM     = 4'd9
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RECV    = 3'd1,
    PH_START   = 3'd2,
    PH_DATA    = 3'd3,
    PH_STOP    = 3'd4,
    PH_STOP2   = 3'd5,
    PH_DONE    = 3'd6,
    PH_BACKOFF = 3'd7
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ESCAPE_CODE = 3'd0,
    CFG_START_CODE  = 3'd1,
    CFG_STOP_CODE   = 3'd2,
    CFG_OWN_ADDRESS = 3'd3,
    CFG_CONFIGURED  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic load_en;
    logic load_last;
    logic clear_full;
  } slot_ctl_t;

endpackage

// ===== rtl/bus_slave_framer_backoff.sv =====
// Top level of the bus slave framer with discovery backoff.
// The block takes one event item per clock cycle unless stalled, and returns exactly one
// result item for it, which appears in the cycle after acceptance; a new item is taken
// while the previous result is being taken. Packet bytes live in a store with registered read
// addressed by the next send position, so each transmit-ready event finds its byte waiting.
// Configuration writes are always taken and should be made while no item is in flight.
`include "bus_slave_framer_backoff_macros.svh"

module bus_slave_framer_backoff #(
  parameter int unsigned MAX_PACKET = bsfb_pkg::MaxPacketDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bsfb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [3:0]                   kind_i,
  input  logic [7:0]                   query_address_i,
  input  logic [3:0]                   random_nibble_i,
  input  logic [7:0]                   load_data_i,
  input  logic                         load_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         tx_valid_o,
  output logic [7:0]                   tx_byte_o,
  output logic                         driver_enable_o,
  output logic                         edge_watch_o,
  output logic [2:0]                   bus_phase_o,
  output logic                         slot_full_o,
  output logic                         load_error_o,
  output logic                         message_ready_o
);
  import bsfb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PACKET + 1);

  logic [7:0] escape_q, start_q, stop_q, own_q;
  logic       configured_q;

  phase_e          phase_q, phase_d;
  logic [4:0]      backoff_q, backoff_d;
  logic [4:0]      random_q, random_d;
  logic [CntW-1:0] send_pos_q, send_pos_d;
  logic [CntW-1:0] pos_inc;
  logic            esc_sent_q, esc_sent_d;
  logic            driver_q, driver_d;
  logic            watch_q, watch_d;

  slot_ctl_t       slot_ctl;
  logic            slot_full, slot_full_next, slot_load_error;
  logic [CntW-1:0] slot_length;
  logic [7:0]      slot_rd_data;

  logic       in_acc, sending, frame_go;
  logic       tx_valid_d;
  logic [7:0] tx_byte_d;
  logic       msg_ready_d;

  logic       out_valid_q;
  logic       tx_valid_q, driver_out_q, watch_out_q, full_out_q, load_error_q, msg_ready_q;
  logic [7:0] tx_byte_q;
  logic [2:0] phase_out_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc = in_valid_i && in_ready_o;
  assign sending = (phase_q == PH_START) || (phase_q == PH_DATA) || (phase_q == PH_STOP) ||
                   (phase_q == PH_STOP2) || (phase_q == PH_DONE);
  assign pos_inc = send_pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q <= '0;
      start_q <= '0;
      stop_q <= '0;
      own_q <= '0;
      configured_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ESCAPE_CODE: escape_q <= cfg_data_i;
        CFG_START_CODE:  start_q <= cfg_data_i;
        CFG_STOP_CODE:   stop_q <= cfg_data_i;
        CFG_OWN_ADDRESS: own_q <= cfg_data_i;
        CFG_CONFIGURED:  configured_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    backoff_d = backoff_q;
    random_d = random_q;
    send_pos_d = send_pos_q;
    esc_sent_d = esc_sent_q;
    driver_d = driver_q;
    watch_d = watch_q;
    tx_valid_d = 1'b0;
    tx_byte_d = '0;
    msg_ready_d = 1'b0;
    slot_ctl = '0;
    slot_ctl.load_last = load_last_i;
    frame_go = 1'b0;
    if (in_acc) begin
      unique case (kind_e'(kind_i))
        KIND_RX_MESSAGE: begin
          if (!sending) begin
            watch_d = 1'b0;
            backoff_d = '0;
            phase_d = PH_RECV;
          end
        end
        KIND_QUERY: begin
          if (!sending && configured_q && (query_address_i == own_q)) begin
            frame_go = slot_full;
          end
        end
        KIND_DISCOVER: begin
          if (!sending && !configured_q && (random_q != '0)) begin
            phase_d = PH_BACKOFF;
            backoff_d = random_q;
            random_d = '0;
            watch_d = 1'b1;
          end
        end
        KIND_EDGE: begin
          if (phase_q == PH_BACKOFF) begin
            watch_d = 1'b0;
            backoff_d = '0;
            phase_d = PH_IDLE;
          end
        end
        KIND_TICK: begin
          if (phase_q == PH_BACKOFF) begin
            backoff_d = (backoff_q != '0) ? backoff_q - 1'b1 : '0;
            if (backoff_d == '0) begin
              watch_d = 1'b0;
              if (slot_full) begin
                frame_go = 1'b1;
              end else begin
                phase_d = PH_IDLE;
              end
            end
          end
        end
        KIND_TX_READY: begin
          if (phase_q == PH_START) begin
            tx_valid_d = 1'b1;
            tx_byte_d = start_q;
            send_pos_d = '0;
            phase_d = PH_DATA;
          end else if (phase_q == PH_DATA) begin
            tx_valid_d = 1'b1;
            if ((slot_rd_data == escape_q) && !esc_sent_q) begin
              tx_byte_d = escape_q;
              esc_sent_d = 1'b1;
            end else begin
              esc_sent_d = 1'b0;
              tx_byte_d = slot_rd_data;
              send_pos_d = pos_inc;
              if (pos_inc >= slot_length) begin
                slot_ctl.clear_full = 1'b1;
                phase_d = PH_STOP;
              end
            end
          end else if (phase_q == PH_STOP) begin
            tx_valid_d = 1'b1;
            tx_byte_d = escape_q;
            phase_d = PH_STOP2;
          end else if (phase_q == PH_STOP2) begin
            tx_valid_d = 1'b1;
            tx_byte_d = stop_q;
            phase_d = PH_DONE;
          end
        end
        KIND_TX_END: begin
          if (phase_q == PH_DONE) begin
            phase_d = PH_IDLE;
            driver_d = 1'b0;
          end
        end
        KIND_LOAD: begin
          slot_ctl.load_en = 1'b1;
        end
        KIND_FETCH: begin
          if (phase_q == PH_RECV) begin
            msg_ready_d = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        KIND_RANDOM: begin
          if (random_q == '0) begin
            random_d = {1'b0, random_nibble_i} + 5'd1;
          end
        end
        default: ;
      endcase
      if (frame_go) begin
        driver_d = 1'b1;
        watch_d = 1'b0;
        backoff_d = '0;
        esc_sent_d = 1'b0;
        send_pos_d = '0;
        phase_d = PH_START;
        tx_valid_d = 1'b1;
        tx_byte_d = escape_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      backoff_q <= '0;
      random_q <= '0;
      send_pos_q <= '0;
      esc_sent_q <= 1'b0;
      driver_q <= 1'b0;
      watch_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      backoff_q <= backoff_d;
      random_q <= random_d;
      send_pos_q <= send_pos_d;
      esc_sent_q <= esc_sent_d;
      driver_q <= driver_d;
      watch_q <= watch_d;
    end
  end

  bsfb_slot #(
    .MaxPacket(MAX_PACKET)
  ) u_slot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (slot_ctl),
    .load_data_i (load_data_i),
    .rd_addr_i   (send_pos_d),
    .full_o      (slot_full),
    .full_next_o (slot_full_next),
    .load_error_o(slot_load_error),
    .length_o    (slot_length),
    .rd_data_o   (slot_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tx_valid_q <= tx_valid_d;
      tx_byte_q <= tx_byte_d;
      driver_out_q <= driver_d;
      watch_out_q <= watch_d;
      phase_out_q <= phase_d;
      full_out_q <= slot_full_next;
      load_error_q <= slot_load_error;
      msg_ready_q <= msg_ready_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_valid_o = tx_valid_q;
  assign tx_byte_o = tx_byte_q;
  assign driver_enable_o = driver_out_q;
  assign edge_watch_o = watch_out_q;
  assign bus_phase_o = phase_out_q;
  assign slot_full_o = full_out_q;
  assign load_error_o = load_error_q;
  assign message_ready_o = msg_ready_q;

  `BSFB_ASSERT(a_driver_while_sending, !sending || driver_q, "driver off during a frame")
  `BSFB_ASSERT(a_watch_only_in_backoff, watch_q == (phase_q == PH_BACKOFF),
               "edge watch out of backoff")
  `BSFB_ASSERT(a_data_has_packet,
               (phase_q != PH_DATA) || (slot_full && (send_pos_q < slot_length)),
               "data phase without bytes left")
  `BSFB_ASSERT_NEXT(a_frame_starts_idle_escape, in_acc && frame_go,
                    phase_q == PH_START && !esc_sent_q && send_pos_q == '0,
                    "frame start state wrong")

endmodule

// ===== rtl/bsfb_slot.sv =====
// Packet slot: byte store with registered read, fill count, length and full flag.
`include "bus_slave_framer_backoff_macros.svh"

module bsfb_slot #(
  parameter int unsigned MaxPacket = bsfb_pkg::MaxPacketDefault,
  localparam int unsigned CntW = $clog2(MaxPacket + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsfb_pkg::slot_ctl_t ctl_i,
  input  logic [7:0]         load_data_i,
  input  logic [CntW-1:0]    rd_addr_i,
  output logic               full_o,
  output logic               full_next_o,
  output logic               load_error_o,
  output logic [CntW-1:0]    length_o,
  output logic [7:0]         rd_data_o
);
  import bsfb_pkg::*;

  localparam int unsigned AddrW = (MaxPacket > 1) ? $clog2(MaxPacket) : 1;

  logic [7:0]      mem [MaxPacket];
  logic [7:0]      rd_data_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] length_q, length_d;
  logic            full_q, full_d;
  logic            we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign waddr = fill_q[AddrW-1:0];
  assign raddr = rd_addr_i[AddrW-1:0];
  assign we = ctl_i.load_en && !full_q && (fill_q < CntW'(MaxPacket));

  always_comb begin
    fill_d = fill_q;
    length_d = length_q;
    full_d = full_q;
    load_error_o = 1'b0;
    if (ctl_i.clear_full) begin
      full_d = 1'b0;
    end
    if (ctl_i.load_en) begin
      if (full_q) begin
        load_error_o = 1'b1;
      end else if (fill_q >= CntW'(MaxPacket)) begin
        load_error_o = 1'b1;
        fill_d = '0;
      end else begin
        fill_d = fill_q + 1'b1;
        if (ctl_i.load_last) begin
          length_d = fill_q + 1'b1;
          full_d = 1'b1;
          fill_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      length_q <= '0;
      full_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      length_q <= length_d;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= load_data_i;
    end
  end

  // A write to the entry being read is passed straight to the read register.
  always_ff @(posedge clk_i) begin
    if (we && (waddr == raddr)) begin
      rd_data_q <= load_data_i;
    end else begin
      rd_data_q <= mem[raddr];
    end
  end

  assign full_o = full_q;
  assign full_next_o = full_d;
  assign length_o = length_q;
  assign rd_data_o = rd_data_q;

  `BSFB_ASSERT(a_fill_idle_when_full, !full_q || (fill_q == '0), "fill count busy while slot full")
  `BSFB_ASSERT(a_length_nonzero, !full_q || (length_q != '0), "full slot with zero length")
  `BSFB_ASSERT(a_fill_bound, fill_q <= CntW'(MaxPacket), "fill count beyond slot size")

endmodule
